/* rtl/ccpa_pkg.sv */
// Shared types and constants for the up/down pulse counter with period averages.
package ccpa_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_CW     = 2'd0;
    localparam logic [1:0] CMD_CCW    = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SAMPLES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCKS_PER_US = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT    = 3'd4;

    // Field widths.
    localparam int WORD_W    = 32;
    localparam int SAMPLES_W = 16;
    localparam int CPM_W     = 10;
    localparam int CFG_DATA_W = 32;

    // Divider: dividend holds avg*(N-1)+t, divisor holds N or the clock rate.
    localparam int PROD_W     = WORD_W + SAMPLES_W;
    localparam int DIVIDEND_W = PROD_W + 1;
    localparam int DIVISOR_W  = SAMPLES_W;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Which quantity a division produces.
    localparam logic [1:0] DSEL_TE    = 2'd0;
    localparam logic [1:0] DSEL_SHORT = 2'd1;
    localparam logic [1:0] DSEL_LONG  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       apply;
        logic       mul_short;
        logic       mul_long;
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_out;
    } ccpa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic avg_needed;
        logic div_done;
    } ccpa_status_t;

endpackage

/* rtl/ccpa_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module ccpa_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ccpa_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [ccpa_pkg::DIVISOR_W-1:0]       divisor,
    output logic                                 done,
    output logic [ccpa_pkg::WORD_W-1:0]          quotient
);

    logic                                busy_reg;
    logic                                busy_next;
    logic                                done_reg;
    logic                                done_next;
    logic [ccpa_pkg::DIV_CNT_W-1:0]      count_reg;
    logic [ccpa_pkg::DIV_CNT_W-1:0]      count_next;
    logic [ccpa_pkg::DIVIDEND_W-1:0]     q_reg;
    logic [ccpa_pkg::DIVIDEND_W-1:0]     q_next;
    logic [ccpa_pkg::DIVISOR_W-1:0]      rem_reg;
    logic [ccpa_pkg::DIVISOR_W-1:0]      rem_next;
    logic [ccpa_pkg::DIVISOR_W-1:0]      divisor_reg;
    logic [ccpa_pkg::DIVISOR_W-1:0]      divisor_next;
    logic [ccpa_pkg::DIVISOR_W:0]        rem_shift;
    logic [ccpa_pkg::DIVISOR_W:0]        rem_diff;
    logic                                fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, q_reg[ccpa_pkg::DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
    end

    // Sequencing of the steps.
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = ccpa_pkg::DIV_CNT_W'(ccpa_pkg::DIV_STEPS - 1);
            q_next       = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[ccpa_pkg::DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_diff[ccpa_pkg::DIVISOR_W-1:0]
                            : rem_shift[ccpa_pkg::DIVISOR_W-1:0];
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Control flops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg[ccpa_pkg::WORD_W-1:0];

endmodule

/* rtl/ccpa_dp.sv */
// Datapath: configuration, position and timing state, averaging arithmetic, result registers.
module ccpa_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ccpa_pkg::ccpa_cmd_t                   cmd,
    output ccpa_pkg::ccpa_status_t                status,
    input  logic                                  cfg_we,
    input  logic [ccpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ccpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [1:0]                            command,
    input  logic [ccpa_pkg::WORD_W-1:0]           timestamp,
    input  logic signed [ccpa_pkg::WORD_W-1:0]    position_value,
    output logic signed [ccpa_pkg::WORD_W-1:0]    position,
    output logic [ccpa_pkg::WORD_W-1:0]           short_average_us,
    output logic [ccpa_pkg::WORD_W-1:0]           long_average_us,
    output logic                                  fast_motion,
    output logic                                  slow_motion
);

    // Configuration registers.
    logic [ccpa_pkg::SAMPLES_W-1:0] short_samples_reg;
    logic [ccpa_pkg::SAMPLES_W-1:0] long_samples_reg;
    logic [ccpa_pkg::WORD_W-1:0]    min_period_reg;
    logic [ccpa_pkg::CPM_W-1:0]     cpm_reg;
    logic [ccpa_pkg::WORD_W-1:0]    slow_limit_reg;

    // Block state.
    logic [ccpa_pkg::WORD_W-1:0]    pulse_count_reg;
    logic [ccpa_pkg::WORD_W-1:0]    pulse_count_next;
    logic [ccpa_pkg::WORD_W-1:0]    last_pulse_time_reg;
    logic [ccpa_pkg::WORD_W-1:0]    last_pulse_time_next;
    logic [ccpa_pkg::WORD_W-1:0]    last_elapsed_reg;
    logic [ccpa_pkg::WORD_W-1:0]    last_elapsed_next;
    logic [ccpa_pkg::WORD_W-1:0]    short_avg_reg;
    logic [ccpa_pkg::WORD_W-1:0]    short_avg_next;
    logic [ccpa_pkg::WORD_W-1:0]    long_avg_reg;
    logic [ccpa_pkg::WORD_W-1:0]    long_avg_next;
    logic [ccpa_pkg::WORD_W-1:0]    last_avg_time_reg;
    logic [ccpa_pkg::WORD_W-1:0]    last_avg_time_next;

    // Captured transaction and working values.
    logic [1:0]                     cmd_reg;
    logic [ccpa_pkg::WORD_W-1:0]    ts_reg;
    logic [ccpa_pkg::WORD_W-1:0]    pv_reg;
    logic [ccpa_pkg::WORD_W-1:0]    te_reg;
    logic [ccpa_pkg::WORD_W-1:0]    te_next;
    logic [ccpa_pkg::PROD_W-1:0]    prod_reg;
    logic [1:0]                     div_sel_reg;

    // Result registers.
    logic [ccpa_pkg::WORD_W-1:0]    position_reg;
    logic [ccpa_pkg::WORD_W-1:0]    short_out_reg;
    logic [ccpa_pkg::WORD_W-1:0]    long_out_reg;
    logic                           fast_reg;
    logic                           slow_reg;

    // Derived values.
    logic [ccpa_pkg::WORD_W-1:0]    elapsed;
    logic                           is_pulse;
    logic                           avg_needed;
    logic [ccpa_pkg::SAMPLES_W-1:0] short_n;
    logic [ccpa_pkg::SAMPLES_W-1:0] long_n;
    logic [ccpa_pkg::DIVISOR_W-1:0] cpm_div;
    logic [ccpa_pkg::SAMPLES_W-1:0] mul_n;
    logic [ccpa_pkg::WORD_W-1:0]    mul_avg;
    logic [ccpa_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [ccpa_pkg::DIVISOR_W-1:0] div_divisor;
    logic                           div_done;
    logic [ccpa_pkg::WORD_W-1:0]    div_quotient;

    // Zero weights and a zero clock rate act as one.
    assign short_n = (short_samples_reg == '0) ? ccpa_pkg::SAMPLES_W'(1) : short_samples_reg;
    assign long_n  = (long_samples_reg == '0) ? ccpa_pkg::SAMPLES_W'(1) : long_samples_reg;
    assign cpm_div = (cpm_reg == '0) ? ccpa_pkg::DIVISOR_W'(1)
                                     : ccpa_pkg::DIVISOR_W'(cpm_reg);

    // Pulse timing against the previous pulse.
    assign elapsed    = ts_reg - last_pulse_time_reg;
    assign is_pulse   = (cmd_reg == ccpa_pkg::CMD_CW) || (cmd_reg == ccpa_pkg::CMD_CCW);
    assign avg_needed = is_pulse && (elapsed > min_period_reg);

    assign status.avg_needed = avg_needed;
    assign status.div_done   = div_done;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_samples_reg <= ccpa_pkg::SAMPLES_W'(1);
            long_samples_reg  <= ccpa_pkg::SAMPLES_W'(1);
            min_period_reg    <= '0;
            cpm_reg           <= ccpa_pkg::CPM_W'(1);
            slow_limit_reg    <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ccpa_pkg::REG_SHORT_SAMPLES: short_samples_reg <= cfg_data[ccpa_pkg::SAMPLES_W-1:0];
                ccpa_pkg::REG_LONG_SAMPLES:  long_samples_reg  <= cfg_data[ccpa_pkg::SAMPLES_W-1:0];
                ccpa_pkg::REG_MIN_PERIOD:    min_period_reg    <= cfg_data[ccpa_pkg::WORD_W-1:0];
                ccpa_pkg::REG_CLOCKS_PER_US: cpm_reg           <= cfg_data[ccpa_pkg::CPM_W-1:0];
                ccpa_pkg::REG_SLOW_LIMIT:    slow_limit_reg    <= cfg_data[ccpa_pkg::WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider operands: the microsecond conversion, or one of the two blends.
    always_comb
    begin
        div_dividend = {{(ccpa_pkg::DIVIDEND_W - ccpa_pkg::WORD_W){1'b0}}, elapsed};
        div_divisor  = cpm_div;
        case (cmd.div_sel)
            ccpa_pkg::DSEL_SHORT:
            begin
                div_dividend = {1'b0, prod_reg}
                             + ccpa_pkg::DIVIDEND_W'(te_reg);
                div_divisor  = short_n;
            end
            ccpa_pkg::DSEL_LONG:
            begin
                div_dividend = {1'b0, prod_reg}
                             + ccpa_pkg::DIVIDEND_W'(te_reg);
                div_divisor  = long_n;
            end
            default: ;
        endcase
    end

    ccpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // State update for the captured transaction and the division results.
    always_comb
    begin
        pulse_count_next     = pulse_count_reg;
        last_pulse_time_next = last_pulse_time_reg;
        last_elapsed_next    = last_elapsed_reg;
        last_avg_time_next   = last_avg_time_reg;
        short_avg_next       = short_avg_reg;
        long_avg_next        = long_avg_reg;
        te_next              = te_reg;
        if (cmd.apply)
        begin
            case (cmd_reg)
                ccpa_pkg::CMD_CW:   pulse_count_next = pulse_count_reg + 1'b1;
                ccpa_pkg::CMD_CCW:  pulse_count_next = pulse_count_reg - 1'b1;
                ccpa_pkg::CMD_LOAD: pulse_count_next = pv_reg;
                default: ;
            endcase
            if (is_pulse)
            begin
                last_pulse_time_next = ts_reg;
                last_elapsed_next    = elapsed;
            end
            if (avg_needed)
            begin
                last_avg_time_next = ts_reg;
            end
        end
        if (div_done)
        begin
            case (div_sel_reg)
                ccpa_pkg::DSEL_TE:    te_next        = div_quotient;
                ccpa_pkg::DSEL_SHORT: short_avg_next = div_quotient;
                ccpa_pkg::DSEL_LONG:  long_avg_next  = div_quotient;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg     <= '0;
            last_pulse_time_reg <= '0;
            last_elapsed_reg    <= '0;
            last_avg_time_reg   <= '0;
            short_avg_reg       <= '0;
            long_avg_reg        <= '0;
        end
        else
        begin
            pulse_count_reg     <= pulse_count_next;
            last_pulse_time_reg <= last_pulse_time_next;
            last_elapsed_reg    <= last_elapsed_next;
            last_avg_time_reg   <= last_avg_time_next;
            short_avg_reg       <= short_avg_next;
            long_avg_reg        <= long_avg_next;
        end
    end

    // Multiplier operands: the average and its weight minus one.
    assign mul_n   = cmd.mul_long ? (long_n - 1'b1) : (short_n - 1'b1);
    assign mul_avg = cmd.mul_long ? long_avg_reg : short_avg_reg;

    // Transaction capture, product, division tag and result registers.
    always_ff @(posedge clk)
    begin
        te_reg <= te_next;
        if (cmd.capture)
        begin
            cmd_reg <= command;
            ts_reg  <= timestamp;
            pv_reg  <= position_value;
        end
        if (cmd.mul_short || cmd.mul_long)
        begin
            prod_reg <= mul_avg * mul_n;
        end
        if (cmd.div_start)
        begin
            div_sel_reg <= cmd.div_sel;
        end
        if (cmd.load_out)
        begin
            position_reg  <= pulse_count_reg;
            short_out_reg <= short_avg_reg;
            long_out_reg  <= long_avg_reg;
            fast_reg      <= (last_elapsed_reg < min_period_reg);
            slow_reg      <= ((ts_reg - last_avg_time_reg) > slow_limit_reg);
        end
    end

    assign position         = position_reg;
    assign short_average_us = short_out_reg;
    assign long_average_us  = long_out_reg;
    assign fast_motion      = fast_reg;
    assign slow_motion      = slow_reg;

endmodule

/* rtl/ccpa_ctrl.sv */
// Controller: sequences each transaction through the update and, for an averaged pulse, conversion and both blends.
module ccpa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  ccpa_pkg::ccpa_status_t  status,
    output ccpa_pkg::ccpa_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_APPLY   = 4'd1;
    localparam logic [3:0] S_WAIT_TE = 4'd2;
    localparam logic [3:0] S_MUL_S   = 4'd3;
    localparam logic [3:0] S_GO_S    = 4'd4;
    localparam logic [3:0] S_WAIT_S  = 4'd5;
    localparam logic [3:0] S_MUL_L   = 4'd6;
    localparam logic [3:0] S_GO_L    = 4'd7;
    localparam logic [3:0] S_WAIT_L  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = ccpa_pkg::DSEL_TE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (status.avg_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAIT_TE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WAIT_TE:
            begin
                if (status.div_done)
                begin
                    state_next = S_MUL_S;
                end
            end
            S_MUL_S:
            begin
                cmd.mul_short = 1'b1;
                state_next    = S_GO_S;
            end
            S_GO_S:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ccpa_pkg::DSEL_SHORT;
                state_next    = S_WAIT_S;
            end
            S_WAIT_S:
            begin
                if (status.div_done)
                begin
                    state_next = S_MUL_L;
                end
            end
            S_MUL_L:
            begin
                cmd.mul_long = 1'b1;
                state_next   = S_GO_L;
            end
            S_GO_L:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ccpa_pkg::DSEL_LONG;
                state_next    = S_WAIT_L;
            end
            S_WAIT_L:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/cw_ccw_counter_with_period_average.sv */
// Top level of the up/down pulse counter with short- and long-term period averages.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------------
//  input    in_valid / in_stall    command, timestamp, position_value
//  output   out_valid / out_stall  position, short_average_us, long_average_us,
//                                  fast_motion, slow_motion
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load, a query or an unaveraged pulse goes from capture through the update to the output register.
// An averaged pulse also takes three 49-step passes of the one-bit-per-cycle divider
// (clock conversion, short blend, long blend) before its result is written.
// A transaction can be accepted while the previous result still waits in the output register.
// Reset restores the register defaults and clears position, averages and timestamps.
// A stalled output holds its payload; the block then stops before writing the next result.
module cw_ccw_counter_with_period_average (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            command,
    input  logic [ccpa_pkg::WORD_W-1:0]           timestamp,
    input  logic signed [ccpa_pkg::WORD_W-1:0]    position_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ccpa_pkg::WORD_W-1:0]    position,
    output logic [ccpa_pkg::WORD_W-1:0]           short_average_us,
    output logic [ccpa_pkg::WORD_W-1:0]           long_average_us,
    output logic                                  fast_motion,
    output logic                                  slow_motion,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ccpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ccpa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ccpa_pkg::ccpa_cmd_t    cmd;
    ccpa_pkg::ccpa_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    ccpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ccpa_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .timestamp        (timestamp),
        .position_value   (position_value),
        .position         (position),
        .short_average_us (short_average_us),
        .long_average_us  (long_average_us),
        .fast_motion      (fast_motion),
        .slow_motion      (slow_motion)
    );

endmodule

/* tb/ccpa_checker.sv */
// Checker for the pulse counter: watches all three channels, predicts each result and compares.
`timescale 1ns / 100ps

module ccpa_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic [1:0]                            command,
    input  logic [ccpa_pkg::WORD_W-1:0]           timestamp,
    input  logic signed [ccpa_pkg::WORD_W-1:0]    position_value,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [ccpa_pkg::WORD_W-1:0]    position,
    input  logic [ccpa_pkg::WORD_W-1:0]           short_average_us,
    input  logic [ccpa_pkg::WORD_W-1:0]           long_average_us,
    input  logic                                  fast_motion,
    input  logic                                  slow_motion,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [ccpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ccpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    error_count,
    output int                                    pending_count
);

    // One predicted result of the block.
    typedef struct packed {
        logic [31:0] position;
        logic [31:0] short_us;
        logic [31:0] long_us;
        logic        fast;
        logic        slow;
    } period_report_t;

    period_report_t report_queue[$];

    // Register copies.
    logic [15:0] short_weight;
    logic [15:0] long_weight;
    logic [31:0] min_period;
    logic [9:0]  clocks_per_us;
    logic [31:0] slow_limit;

    // Counter and timing state.
    logic [31:0] pos_count;
    logic [31:0] last_pulse_ts;
    logic [31:0] last_gap;
    logic [31:0] short_avg;
    logic [31:0] long_avg;
    logic [31:0] last_avg_ts;

    // Weighted running average with a wide intermediate; a weight of zero acts as one.
    function automatic logic [31:0] blend_average(input logic [31:0] avg,
                                                  input logic [15:0] weight,
                                                  input logic [31:0] sample);
        logic [63:0] n;
        logic [63:0] acc;
        n = (weight == 16'd0) ? 64'd1 : {48'd0, weight};
        acc = {32'd0, avg} * (n - 64'd1) + {32'd0, sample};
        acc = acc / n;
        return acc[31:0];
    endfunction

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        period_report_t want;
        period_report_t got;
        logic           take_pulse;
        logic [31:0]    elapsed;
        logic [31:0]    rate;
        logic [31:0]    sample;
        logic [31:0]    since_avg;

        if (!rst_n)
        begin
            short_weight  = 16'd1;
            long_weight   = 16'd1;
            min_period    = 32'd0;
            clocks_per_us = 10'd1;
            slow_limit    = 32'hFFFF_FFFF;
            pos_count     = 32'd0;
            last_pulse_ts = 32'd0;
            last_gap      = 32'd0;
            short_avg     = 32'd0;
            long_avg      = 32'd0;
            last_avg_ts   = 32'd0;
            report_queue.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            // Compare an accepted result with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (report_queue.size() == 0)
                begin
                    $display("%0t: result with no transaction pending: position %h",
                             $time, position);
                    error_count++;
                end
                else
                begin
                    want = report_queue.pop_front();
                    got.position = position;
                    got.short_us = short_average_us;
                    got.long_us  = long_average_us;
                    got.fast     = fast_motion;
                    got.slow     = slow_motion;
                    check_field("position", want.position, got.position);
                    check_field("short_average_us", want.short_us, got.short_us);
                    check_field("long_average_us", want.long_us, got.long_us);
                    check_field("fast_motion", {31'd0, want.fast}, {31'd0, got.fast});
                    check_field("slow_motion", {31'd0, want.slow}, {31'd0, got.slow});
                end
            end

            // Track register writes; unused indexes change nothing.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ccpa_pkg::REG_SHORT_SAMPLES: short_weight  = cfg_data[15:0];
                    ccpa_pkg::REG_LONG_SAMPLES:  long_weight   = cfg_data[15:0];
                    ccpa_pkg::REG_MIN_PERIOD:    min_period    = cfg_data;
                    ccpa_pkg::REG_CLOCKS_PER_US: clocks_per_us = cfg_data[9:0];
                    ccpa_pkg::REG_SLOW_LIMIT:    slow_limit    = cfg_data;
                    default: ;
                endcase
            end

            // Predict the result of an accepted input transaction.
            if (in_valid && !in_stall)
            begin
                take_pulse = 1'b0;
                case (command)
                    ccpa_pkg::CMD_CW:
                    begin
                        pos_count  = pos_count + 32'd1;
                        take_pulse = 1'b1;
                    end
                    ccpa_pkg::CMD_CCW:
                    begin
                        pos_count  = pos_count - 32'd1;
                        take_pulse = 1'b1;
                    end
                    ccpa_pkg::CMD_LOAD:
                        pos_count = position_value;
                    default: ;
                endcase

                if (take_pulse)
                begin
                    elapsed       = timestamp - last_pulse_ts;
                    last_pulse_ts = timestamp;
                    last_gap      = elapsed;
                    // Only periods strictly above the minimum enter the averages.
                    if (elapsed > min_period)
                    begin
                        rate        = (clocks_per_us == 10'd0) ? 32'd1 : {22'd0, clocks_per_us};
                        sample      = elapsed / rate;
                        last_avg_ts = timestamp;
                        short_avg   = blend_average(short_avg, short_weight, sample);
                        long_avg    = blend_average(long_avg, long_weight, sample);
                    end
                end

                since_avg     = timestamp - last_avg_ts;
                want.position = pos_count;
                want.short_us = short_avg;
                want.long_us  = long_avg;
                want.fast     = (last_gap < min_period);
                want.slow     = (since_avg > slow_limit);
                report_queue.push_back(want);
            end

            pending_count = report_queue.size();
        end
    end

endmodule

/* tb/tb_cw_ccw_counter_with_period_average.sv */
// Testbench top for the pulse counter: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_cw_ccw_counter_with_period_average;

    localparam int CYCLE_LIMIT     = 2000000;
    // An averaged pulse is the longest transaction inside the block.
    localparam int SETTLE_CYCLES   = 200;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SIDE_INPUT      = 0;
    localparam int SIDE_OUTPUT     = 1;
    localparam logic [ccpa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic [1:0]                            command;
    logic [ccpa_pkg::WORD_W-1:0]           timestamp;
    logic signed [ccpa_pkg::WORD_W-1:0]    position_value;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [ccpa_pkg::WORD_W-1:0]    position;
    logic [ccpa_pkg::WORD_W-1:0]           short_average_us;
    logic [ccpa_pkg::WORD_W-1:0]           long_average_us;
    logic                                  fast_motion;
    logic                                  slow_motion;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [ccpa_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [ccpa_pkg::CFG_DATA_W-1:0]       cfg_data;

    int error_count;
    int pending_count;
    int cycle_count;
    int quiet_left[2];

    // Stimulus shaping follows the minimum period currently programmed.
    logic [31:0] cur_min;
    logic [31:0] last_ts;

    cw_ccw_counter_with_period_average uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .timestamp        (timestamp),
        .position_value   (position_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .position         (position),
        .short_average_us (short_average_us),
        .long_average_us  (long_average_us),
        .fast_motion      (fast_motion),
        .slow_motion      (slow_motion),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    ccpa_checker period_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .timestamp        (timestamp),
        .position_value   (position_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .position         (position),
        .short_average_us (short_average_us),
        .long_average_us  (long_average_us),
        .fast_motion      (fast_motion),
        .slow_motion      (slow_motion),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before a transaction, with occasional stretches of none at all.
    function automatic int draw_wait(input int side);
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            quiet_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // Offer one input transaction and hold it until accepted.
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] ts,
                             input logic [31:0] pv);
        int gap;
        gap = draw_wait(SIDE_INPUT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command        <= cmd;
        timestamp      <= ts;
        position_value <= pv;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ccpa_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every predicted result has arrived and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program all registers while idle; unused upper data bits carry junk.
    task automatic configure(input logic [15:0] short_n, input logic [15:0] long_n,
                             input logic [31:0] min_clk, input logic [9:0] cpm,
                             input logic [31:0] slow_clk);
        logic [31:0] junk;
        settle();
        junk = $urandom();
        write_reg(ccpa_pkg::REG_SHORT_SAMPLES, {junk[31:16], short_n});
        junk = $urandom();
        write_reg(ccpa_pkg::REG_LONG_SAMPLES, {junk[31:16], long_n});
        write_reg(ccpa_pkg::REG_MIN_PERIOD, min_clk);
        junk = $urandom();
        write_reg(ccpa_pkg::REG_CLOCKS_PER_US, {junk[31:10], cpm});
        write_reg(ccpa_pkg::REG_SLOW_LIMIT, slow_clk);
        write_reg(REG_UNUSED, $urandom());
        cur_min = min_clk;
    endtask

    // Result side back-pressure: a random hold before each result.
    initial
    begin : result_sink
        int hold;
        forever
        begin
            hold = draw_wait(SIDE_OUTPUT);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_cw_ccw_counter_with_period_average: errors");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          n;
        int          roll;
        logic [1:0]  cmd;
        logic [31:0] ts;
        logic [31:0] delta;
        logic [15:0] short_n;
        logic [15:0] long_n;
        logic [31:0] min_clk;
        logic [9:0]  cpm;
        logic [31:0] slow_clk;

        quiet_left[SIDE_INPUT]  = 0;
        quiet_left[SIDE_OUTPUT] = 0;
        cur_min        = 32'd0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= ccpa_pkg::CMD_STATUS;
        timestamp      <= 32'd0;
        position_value <= 32'd0;
        cfg_valid      <= 1'b0;
        cfg_index      <= ccpa_pkg::REG_SHORT_SAMPLES;
        cfg_data       <= 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a query, an elapsed time equal to the minimum, a normal
        // period, a backward timestamp that wraps, and position wrap both ways.
        send_item(ccpa_pkg::CMD_STATUS, 32'd0, 32'hFFFF_FFFF);
        send_item(ccpa_pkg::CMD_CW, 32'd0, $urandom());
        send_item(ccpa_pkg::CMD_CW, 32'd100, $urandom());
        send_item(ccpa_pkg::CMD_CCW, 32'd50, $urandom());
        send_item(ccpa_pkg::CMD_LOAD, 32'd60, 32'h7FFF_FFFF);
        send_item(ccpa_pkg::CMD_CW, 32'd70, $urandom());
        send_item(ccpa_pkg::CMD_LOAD, 32'd75, 32'h8000_0000);
        send_item(ccpa_pkg::CMD_CCW, 32'd80, $urandom());
        send_item(ccpa_pkg::CMD_STATUS, 32'hFFFF_FFFF, $urandom());

        // Zero weight, maximum long weight, zero clock rate, zero slow limit.
        configure(16'd0, 16'd65535, 32'd1000, 10'd0, 32'd0);
        send_item(ccpa_pkg::CMD_CW, 32'd1080, $urandom());
        send_item(ccpa_pkg::CMD_CW, 32'd1580, $urandom());
        send_item(ccpa_pkg::CMD_CW, 32'd2581, $urandom());
        send_item(ccpa_pkg::CMD_STATUS, 32'd2581, $urandom());
        send_item(ccpa_pkg::CMD_STATUS, 32'd2582, $urandom());
        send_item(ccpa_pkg::CMD_CCW, 32'd1000000, $urandom());

        // Largest minimum period, fastest clock rate, slow limit just under the top.
        configure(16'd65535, 16'd1, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFE);
        send_item(ccpa_pkg::CMD_CW, 32'd999999, $urandom());
        send_item(ccpa_pkg::CMD_CW, 32'd1000004, $urandom());
        send_item(ccpa_pkg::CMD_STATUS, 32'd999999, $urandom());
        send_item(ccpa_pkg::CMD_STATUS, 32'd999998, $urandom());
        last_ts = 32'd1000004;

        // Random phases, each with its own register settings.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 4))
                0:       short_n = 16'd0;
                1:       short_n = 16'd1;
                2:       short_n = 16'd65535;
                3:       short_n = 16'($urandom_range(2, 16));
                default: short_n = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       long_n = 16'd0;
                1:       long_n = 16'd1;
                2:       long_n = 16'd65535;
                3:       long_n = 16'($urandom_range(2, 16));
                default: long_n = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 7))
                0:       min_clk = 32'd0;
                1:       min_clk = 32'hFFFF_FFFF;
                2:       min_clk = $urandom();
                default: min_clk = $urandom_range(0, 3000);
            endcase
            case ($urandom_range(0, 4))
                0:       cpm = 10'd0;
                1:       cpm = 10'd1;
                2:       cpm = 10'd1023;
                default: cpm = 10'($urandom_range(1, 1023));
            endcase
            case ($urandom_range(0, 4))
                0:       slow_clk = 32'd0;
                1:       slow_clk = 32'hFFFF_FFFF;
                2:       slow_clk = $urandom();
                default: slow_clk = $urandom_range(0, 20000);
            endcase
            configure(short_n, long_n, min_clk, cpm, slow_clk);

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    cmd = ($urandom_range(0, 1) == 1) ? ccpa_pkg::CMD_CCW : ccpa_pkg::CMD_CW;
                else if (roll < 90)
                    cmd = ccpa_pkg::CMD_LOAD;
                else
                    cmd = ccpa_pkg::CMD_STATUS;

                if (cmd == ccpa_pkg::CMD_CW || cmd == ccpa_pkg::CMD_CCW)
                begin
                    // Pulse periods cluster around the minimum, with some far off.
                    case ($urandom_range(0, 15))
                        0:       delta = cur_min;
                        1:       delta = cur_min + 32'd1;
                        2:       delta = cur_min - 32'd1;
                        3:       delta = $urandom();
                        4:       delta = 32'd0;
                        default: delta = cur_min + $urandom_range(0, 4000);
                    endcase
                    ts      = last_ts + delta;
                    last_ts = ts;
                end
                else if ($urandom_range(0, 3) == 0)
                    ts = $urandom();
                else
                    ts = last_ts + $urandom_range(0, 20000);

                send_item(cmd, ts, $urandom());
            end
        end

        settle();
        if (error_count == 0 && pending_count == 0)
            $display("tb_cw_ccw_counter_with_period_average: clean");
        else
            $display("tb_cw_ccw_counter_with_period_average: errors");
        $finish;
    end

endmodule
